>>> hdl/dhcp_pkg.sv
// Shared types and constants for the DHCP offer/ack responder.
package dhcp_pkg;

    localparam int OPTION_AREA_BYTES = 312;
    localparam int HDR_BYTES         = 240;
    localparam logic [31:0] COOKIE_VALUE = 32'h6382_5363;
    localparam int REPLY_WORDS       = 35;
    localparam int WORD_IDX_W        = $clog2(REPLY_WORDS);

    localparam logic [7:0] MSG_DISCOVER = 8'd1;
    localparam logic [7:0] MSG_REQUEST  = 8'd3;
    localparam logic [7:0] MSG_OFFER    = 8'd2;
    localparam logic [7:0] MSG_ACK      = 8'd5;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_SUBNET   = 8'd1;
    localparam logic [7:0] OPT_ROUTER   = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_SERVER   = 8'd54;
    localparam logic [7:0] OPT_END      = 8'd255;

    localparam logic [1:0] REG_SERVER = 2'd0;
    localparam logic [1:0] REG_LEASE  = 2'd1;
    localparam logic [1:0] REG_SECS   = 2'd2;
    localparam logic [1:0] REG_MASK   = 2'd3;

    // one reply job handed from the parser to the reply builder
    typedef struct packed {
        logic        ack;
        logic [31:0] xid;
        logic [15:0] flags;
        logic [63:0] chaddr0;
        logic [63:0] chaddr1;
    } job_t;

    typedef struct packed {
        logic [31:0] server;
        logic [31:0] lease;
        logic [31:0] secs;
        logic [31:0] mask;
    } cfg_t;

endpackage

>>> hdl/dhcp_rx_parse.sv
// Byte-wide request parser: header checks, field capture and option walk.
module dhcp_rx_parse
    import dhcp_pkg::*;
#(
    parameter int OPT_AREA = OPTION_AREA_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       rx_last,
    output logic       job_push,
    output job_t       job
);

    localparam logic [1:0] PH_CODE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;
    localparam logic [1:0] PH_TYPE = 2'd3;
    localparam logic [10:0] POS_MAX  = 11'd2047;
    localparam logic [10:0] OPT_LO   = 11'(HDR_BYTES);
    localparam logic [10:0] OPT_HI   = 11'(HDR_BYTES + OPT_AREA);

    logic [10:0] pos_reg,    pos_next;
    logic        hdr_reg,    hdr_next;
    logic [31:0] xid_reg,    xid_next;
    logic [15:0] flags_reg,  flags_next;
    logic [63:0] ch0_reg,    ch0_next;
    logic [63:0] ch1_reg,    ch1_next;
    logic [31:0] cookie_reg, cookie_next;
    logic [1:0]  phase_reg,  phase_next;
    logic [7:0]  code_reg,   code_next;
    logic [7:0]  left_reg,   left_next;
    logic [7:0]  mtype_reg,  mtype_next;
    logic        done_reg,   done_next;
    logic        good;

    always_comb
    begin
        pos_next    = pos_reg;
        hdr_next    = hdr_reg;
        xid_next    = xid_reg;
        flags_next  = flags_reg;
        ch0_next    = ch0_reg;
        ch1_next    = ch1_reg;
        cookie_next = cookie_reg;
        phase_next  = phase_reg;
        code_next   = code_reg;
        left_next   = left_reg;
        mtype_next  = mtype_reg;
        done_next   = done_reg;

        if (pos_reg == 11'd0 && rx_byte != 8'd1) hdr_next = 1'b0;
        if (pos_reg == 11'd1 && rx_byte != 8'd1) hdr_next = 1'b0;
        if (pos_reg == 11'd2 && rx_byte != 8'd6) hdr_next = 1'b0;
        if (pos_reg >= 11'd4 && pos_reg <= 11'd7)
            xid_next = {xid_reg[23:0], rx_byte};
        if (pos_reg >= 11'd10 && pos_reg <= 11'd11)
            flags_next = {flags_reg[7:0], rx_byte};
        if (pos_reg >= 11'd28 && pos_reg <= 11'd35)
            ch0_next = {ch0_reg[55:0], rx_byte};
        if (pos_reg >= 11'd36 && pos_reg <= 11'd43)
            ch1_next = {ch1_reg[55:0], rx_byte};
        if (pos_reg >= 11'd236 && pos_reg <= 11'd239)
            cookie_next = {cookie_reg[23:0], rx_byte};

        if (pos_reg >= OPT_LO && pos_reg < OPT_HI && !done_reg)
        begin
            unique case (phase_reg)
                PH_CODE:
                begin
                    if (rx_byte == OPT_END)
                        done_next = 1'b1;
                    else if (rx_byte != OPT_PAD)
                    begin
                        code_next  = rx_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (code_reg == OPT_MSG_TYPE && rx_byte == 8'd1)
                        phase_next = PH_TYPE;
                    else if (rx_byte == 8'd0)
                        phase_next = PH_CODE;
                    else
                    begin
                        left_next  = rx_byte;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                        phase_next = PH_CODE;
                end
                default:
                begin
                    mtype_next = rx_byte;
                    done_next  = 1'b1;
                end
            endcase
        end

        if (pos_reg != POS_MAX)
            pos_next = pos_reg + 11'd1;

        good = (pos_reg >= 11'(HDR_BYTES - 1)) && hdr_next
            && (cookie_next == COOKIE_VALUE)
            && (mtype_next == MSG_DISCOVER || mtype_next == MSG_REQUEST);
    end

    assign job_push    = accept && rx_last && good;
    assign job.ack     = (mtype_next == MSG_REQUEST);
    assign job.xid     = xid_next;
    assign job.flags   = flags_next;
    assign job.chaddr0 = ch0_next;
    assign job.chaddr1 = ch1_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hdr_reg    <= 1'b1;
            xid_reg    <= '0;
            flags_reg  <= '0;
            ch0_reg    <= '0;
            ch1_reg    <= '0;
            cookie_reg <= '0;
            phase_reg  <= PH_CODE;
            code_reg   <= '0;
            left_reg   <= '0;
            mtype_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (rx_last)
            begin
                pos_reg    <= '0;
                hdr_reg    <= 1'b1;
                xid_reg    <= '0;
                flags_reg  <= '0;
                ch0_reg    <= '0;
                ch1_reg    <= '0;
                cookie_reg <= '0;
                phase_reg  <= PH_CODE;
                code_reg   <= '0;
                left_reg   <= '0;
                mtype_reg  <= '0;
                done_reg   <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                hdr_reg    <= hdr_next;
                xid_reg    <= xid_next;
                flags_reg  <= flags_next;
                ch0_reg    <= ch0_next;
                ch1_reg    <= ch1_next;
                cookie_reg <= cookie_next;
                phase_reg  <= phase_next;
                code_reg   <= code_next;
                left_reg   <= left_next;
                mtype_reg  <= mtype_next;
                done_reg   <= done_next;
            end
        end
    end

endmodule

>>> hdl/dhcp_job_fifo.sv
// Two-entry job queue between parser and reply builder.
module dhcp_job_fifo
    import dhcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic empty,
    output logic full
);

    job_t       mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    assign empty   = (cnt_reg == 2'd0);
    assign full    = (cnt_reg == 2'd2);
    assign pop_job = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> hdl/dhcp_tx_build.sv
// Reply builder: walks the 35 reply words of one job into an output register.
module dhcp_tx_build
    import dhcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        job_avail,
    input  job_t        job_in,
    output logic        job_pop,
    output logic        tx_valid,
    input  logic        tx_stall,
    output logic [63:0] tx_word,
    output logic [3:0]  tx_valid_bytes,
    output logic        reply_is_ack,
    output logic        tx_last
);

    localparam logic [WORD_IDX_W-1:0] LAST_IDX = WORD_IDX_W'(REPLY_WORDS - 1);

    job_t                  job_reg;
    logic                  busy_reg;
    logic [WORD_IDX_W-1:0] idx_reg;
    logic                  ov_reg;
    logic [63:0]           word_reg;
    logic [3:0]            nb_reg;
    logic                  ack_reg;
    logic                  last_reg;
    logic                  advance;
    logic [63:0]           w;
    logic [7:0]            mt;
    logic [31:0]           s;

    assign advance  = busy_reg && (!ov_reg || !tx_stall);
    assign job_pop  = !busy_reg && job_avail;
    assign mt       = job_reg.ack ? MSG_ACK : MSG_OFFER;
    assign s        = cfg.server;

    always_comb
    begin
        case (idx_reg)
            6'd0:  w = {8'd2, 8'd1, 8'd6, 8'd0, job_reg.xid};
            6'd1:  w = {16'd0, job_reg.flags, 32'd0};
            6'd2:  w = {cfg.lease, s};
            6'd3:  w = {32'd0, job_reg.chaddr0[63:32]};
            6'd4:  w = {job_reg.chaddr0[31:0], job_reg.chaddr1[63:32]};
            6'd5:  w = {job_reg.chaddr1[31:0], 32'd0};
            6'd29: w = {32'd0, COOKIE_VALUE};
            6'd30: w = {OPT_MSG_TYPE, 8'd1, mt, OPT_SERVER, 8'd4, s[31:8]};
            6'd31: w = {s[7:0], OPT_LEASE, 8'd4, cfg.secs, OPT_SUBNET};
            6'd32: w = {8'd4, cfg.mask, OPT_ROUTER, 8'd4, s[31:24]};
            6'd33: w = {s[23:0], OPT_DNS, 8'd4, s[31:8]};
            6'd34: w = {s[7:0], OPT_END, 48'd0};
            default: w = 64'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job_in;
        if (advance)
        begin
            word_reg <= w;
            nb_reg   <= (idx_reg == LAST_IDX) ? 4'd2 : 4'd8;
            ack_reg  <= job_reg.ack;
            last_reg <= (idx_reg == LAST_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (job_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                    busy_reg <= 1'b0;
            end
            if (advance)
                ov_reg <= 1'b1;
            else if (!tx_stall)
                ov_reg <= 1'b0;
        end
    end

    assign tx_valid       = ov_reg;
    assign tx_word        = word_reg;
    assign tx_valid_bytes = nb_reg;
    assign reply_is_ack   = ack_reg;
    assign tx_last        = last_reg;

endmodule

>>> hdl/dhcp_offer_ack_responder.sv
// Top level of the single-lease DHCP offer/ack responder.
// Accepts one request byte per cycle unless stalled; a good request's reply is queued on
// its last beat. Jobs pass the queue and the job register, reply words the output
// register; one word a cycle unless stalled, 35 words per reply, set by the word counter.
// Two queued jobs may wait; rx_stall rises only when both slots are taken.
// Async active-low reset restores the register defaults and clears all frame state.
module dhcp_offer_ack_responder
    import dhcp_pkg::*;
#(
    parameter int OPT_AREA = OPTION_AREA_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request beats
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    input  logic        rx_last,
    // reply beats
    output logic        tx_valid,
    input  logic        tx_stall,
    output logic [63:0] tx_word,
    output logic [3:0]  tx_valid_bytes,
    output logic        reply_is_ack,
    output logic        tx_last
);

    cfg_t cfg_reg;
    logic rx_accept;
    logic push;
    job_t push_job;
    logic pop;
    job_t pop_job;
    logic q_empty;
    logic q_full;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.server <= 32'hC0A8_0401;
            cfg_reg.lease  <= 32'hC0A8_0402;
            cfg_reg.secs   <= 32'd3600;
            cfg_reg.mask   <= 32'hFFFF_FF00;
        end
        else if (cfg_we && cfg_index[7:2] == 6'd0)
        begin
            unique case (cfg_index[1:0])
                REG_SERVER: cfg_reg.server <= cfg_data;
                REG_LEASE:  cfg_reg.lease  <= cfg_data;
                REG_SECS:   cfg_reg.secs   <= cfg_data;
                default:    cfg_reg.mask   <= cfg_data;
            endcase
        end
    end

    // hold the byte stream only while the job queue is full
    assign rx_stall  = q_full;
    assign rx_accept = rx_valid && !rx_stall;

    dhcp_rx_parse #(
        .OPT_AREA (OPT_AREA)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (rx_accept),
        .rx_byte  (rx_byte),
        .rx_last  (rx_last),
        .job_push (push),
        .job      (push_job)
    );

    dhcp_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    dhcp_tx_build u_build (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .job_avail      (!q_empty),
        .job_in         (pop_job),
        .job_pop        (pop),
        .tx_valid       (tx_valid),
        .tx_stall       (tx_stall),
        .tx_word        (tx_word),
        .tx_valid_bytes (tx_valid_bytes),
        .reply_is_ack   (reply_is_ack),
        .tx_last        (tx_last)
    );

endmodule

>>> tb/dhcp_offer_ack_responder_tb.sv
// Self-checking testbench for the DHCP offer/ack responder: frame stimulus, reply predictor.
`timescale 1ns / 1ps

module dhcp_offer_ack_responder_tb;
    import dhcp_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int REPLY_BYTES     = 274;
    localparam int POS_SAT         = 2047;
    localparam int AREA_END        = HDR_BYTES + OPTION_AREA_BYTES;

    // frame shapes the generator can build
    typedef enum int {
        FR_GOOD, FR_BAD_OP, FR_BAD_HTYPE, FR_BAD_HLEN, FR_BAD_COOKIE, FR_SHORT,
        FR_NO_TYPE, FR_LEN0, FR_TYPE_LONG, FR_END_FIRST, FR_CODE_LAST, FR_OVERRUN,
        FR_LATE, FR_EDGE, FR_HUGE, FR_NOISE
    } frame_kind_t;

    // header filler: random, all zeros, all ones
    typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

    typedef struct {
        frame_kind_t kind;
        logic [7:0]  msg;
        fill_t       fill;
        int          len;       // only for short and noise frames
        int          words;     // reply words known up front, -1 if left to the predictor
    } frame_row_t;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        ack;
        logic        last;
    } reply_beat_t;

    typedef enum logic [1:0] {SC_CODE, SC_LEN, SC_SKIP, SC_TYPE} scan_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = '0;
    logic        rx_last = 1'b0;
    logic        tx_valid;
    logic        tx_stall = 1'b0;
    logic [63:0] tx_word;
    logic [3:0]  tx_valid_bytes;
    logic        reply_is_ack;
    logic        tx_last;

    dhcp_offer_ack_responder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_valid       (rx_valid),
        .rx_stall       (rx_stall),
        .rx_byte        (rx_byte),
        .rx_last        (rx_last),
        .tx_valid       (tx_valid),
        .tx_stall       (tx_stall),
        .tx_word        (tx_word),
        .tx_valid_bytes (tx_valid_bytes),
        .reply_is_ack   (reply_is_ack),
        .tx_last        (tx_last)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Reply predictor: mirror of the per-frame parse state and the registers
    // ------------------------------------------------------------------
    cfg_t        regs;
    int          rx_pos;
    logic        hdr_good;
    logic [31:0] xid_acc;
    logic [15:0] flags_acc;
    logic [63:0] chaddr_acc [2];
    logic [31:0] cookie_acc;
    scan_t       scan_ph;
    logic [7:0]  opt_code;
    logic [7:0]  opt_left;
    logic [7:0]  mtype_acc;
    logic        scan_stop;

    reply_beat_t pending_replies [$];
    int          errors = 0;
    bit          no_idle = 0;     // a phase with no gaps and no stalls

    logic [7:0]  frame_bytes [$];

    task automatic report(input string what);
        errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic void clear_frame_state();
        rx_pos = 0;
        hdr_good = 1'b1;
        xid_acc = '0;
        flags_acc = '0;
        chaddr_acc[0] = '0;
        chaddr_acc[1] = '0;
        cookie_acc = '0;
        scan_ph = SC_CODE;
        opt_code = '0;
        opt_left = '0;
        mtype_acc = '0;
        scan_stop = 1'b0;
    endfunction

    function automatic void write_regs(input logic [7:0] idx, input logic [31:0] val);
        if (idx == {6'd0, REG_SERVER})    regs.server = val;
        else if (idx == {6'd0, REG_LEASE}) regs.lease = val;
        else if (idx == {6'd0, REG_SECS})  regs.secs = val;
        else if (idx == {6'd0, REG_MASK})  regs.mask = val;
    endfunction

    // option TLV walk, one byte
    function automatic void walk_option(input logic [7:0] c);
        if (scan_stop)
            return;
        case (scan_ph)
            SC_CODE:
                if (c == OPT_END)
                    scan_stop = 1'b1;
                else if (c != OPT_PAD)
                begin
                    opt_code = c;
                    scan_ph = SC_LEN;
                end
            SC_LEN:
                if (opt_code == OPT_MSG_TYPE && c == 8'd1)
                    scan_ph = SC_TYPE;
                else if (c == 8'd0)
                    scan_ph = SC_CODE;
                else
                begin
                    opt_left = c;
                    scan_ph = SC_SKIP;
                end
            SC_SKIP:
            begin
                opt_left = opt_left - 8'd1;
                if (opt_left == 8'd0)
                    scan_ph = SC_CODE;
            end
            default:
            begin
                mtype_acc = c;
                scan_stop = 1'b1;
            end
        endcase
    endfunction

    function automatic void put_u32(ref logic [7:0] b [0:279], input int at,
                                    input logic [31:0] v);
        b[at]     = v[31:24];
        b[at + 1] = v[23:16];
        b[at + 2] = v[15:8];
        b[at + 3] = v[7:0];
    endfunction

    // builds the offer/ack image and queues its beats; returns the beat count
    function automatic int queue_reply(input logic ack);
        logic [7:0]  b [0:279];
        reply_beat_t rb;
        int          at;
        int          n;
        logic [7:0]  codes [5];
        logic [31:0] vals [5];
        n = 0;
        for (int i = 0; i < 280; i++)
            b[i] = '0;
        b[0] = 8'd2;
        b[1] = 8'd1;
        b[2] = 8'd6;
        put_u32(b, 4, xid_acc);
        b[10] = flags_acc[15:8];
        b[11] = flags_acc[7:0];
        put_u32(b, 16, regs.lease);
        put_u32(b, 20, regs.server);
        for (int k = 0; k < 16; k++)
            b[28 + k] = chaddr_acc[k / 8][63 - 8 * (k % 8) -: 8];
        put_u32(b, 236, COOKIE_VALUE);
        b[240] = OPT_MSG_TYPE;
        b[241] = 8'd1;
        b[242] = ack ? MSG_ACK : MSG_OFFER;
        codes = '{OPT_SERVER, OPT_LEASE, OPT_SUBNET, OPT_ROUTER, OPT_DNS};
        vals  = '{regs.server, regs.secs, regs.mask, regs.server, regs.server};
        at = 243;
        for (int o = 0; o < 5; o++)
        begin
            b[at] = codes[o];
            b[at + 1] = 8'd4;
            put_u32(b, at + 2, vals[o]);
            at += 6;
        end
        b[at] = OPT_END;
        for (at = 0; at < REPLY_BYTES; at += 8)
        begin
            rb.word = '0;
            for (int k = 0; k < 8; k++)
                rb.word = {rb.word[55:0], b[at + k]};
            rb.nbytes = (REPLY_BYTES - at >= 8) ? 4'd8 : 4'(REPLY_BYTES - at);
            rb.ack = ack;
            rb.last = (at + 8 >= REPLY_BYTES);
            pending_replies.push_back(rb);
            n++;
        end
        return n;
    endfunction

    // one accepted request beat; returns the reply beats it causes
    function automatic int predict_beat(input logic [7:0] c, input logic fin);
        int p;
        int n;
        p = rx_pos;
        n = 0;
        if (p == 0 && c != 8'd1) hdr_good = 1'b0;
        if (p == 1 && c != 8'd1) hdr_good = 1'b0;
        if (p == 2 && c != 8'd6) hdr_good = 1'b0;
        if (p >= 4 && p <= 7)
            xid_acc = {xid_acc[23:0], c};
        if (p >= 10 && p <= 11)
            flags_acc = {flags_acc[7:0], c};
        if (p >= 28 && p <= 43)
            chaddr_acc[(p - 28) / 8] = {chaddr_acc[(p - 28) / 8][55:0], c};
        if (p >= 236 && p <= 239)
            cookie_acc = {cookie_acc[23:0], c};
        if (p >= HDR_BYTES && p < AREA_END)
            walk_option(c);
        if (p < POS_SAT)
            rx_pos = p + 1;
        if (fin)
        begin
            if (p + 1 >= HDR_BYTES && hdr_good && cookie_acc == COOKIE_VALUE &&
                (mtype_acc == MSG_DISCOVER || mtype_acc == MSG_REQUEST))
                n = queue_reply(mtype_acc == MSG_REQUEST);
            clear_frame_state();
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Frame generator
    // ------------------------------------------------------------------
    function automatic void push_rand(input int count);
        for (int i = 0; i < count; i++)
            frame_bytes.push_back(8'($urandom));
    endfunction

    function automatic void pad_to(input int target);
        while (frame_bytes.size() < target)
            frame_bytes.push_back(OPT_PAD);
    endfunction

    // a few pads and unrelated options, placed before or after the type option
    function automatic void push_filler_options();
        int cnt;
        int olen;
        cnt = $urandom_range(0, 3);
        for (int i = 0; i < cnt; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                frame_bytes.push_back(OPT_PAD);
            else
            begin
                olen = $urandom_range(0, 6);
                frame_bytes.push_back(8'($urandom_range(2, 50)));
                frame_bytes.push_back(8'(olen));
                push_rand(olen);
            end
        end
    endfunction

    function automatic void build_frame(input frame_row_t r);
        logic [7:0] fill_byte;
        logic [7:0] cookie [4];
        frame_bytes.delete();
        if (r.kind == FR_NOISE)
        begin
            push_rand(r.len);
            return;
        end
        for (int i = 0; i < 236; i++)
        begin
            case (r.fill)
                FILL_ZERO: fill_byte = 8'h00;
                FILL_ONES: fill_byte = 8'hFF;
                default:   fill_byte = 8'($urandom);
            endcase
            frame_bytes.push_back(fill_byte);
        end
        frame_bytes[0] = 8'd1;
        frame_bytes[1] = 8'd1;
        frame_bytes[2] = 8'd6;
        // a single wrong bit in the fixed header fields
        if (r.kind == FR_BAD_OP)    frame_bytes[0] ^= 8'(1 << $urandom_range(0, 7));
        if (r.kind == FR_BAD_HTYPE) frame_bytes[1] ^= 8'(1 << $urandom_range(0, 7));
        if (r.kind == FR_BAD_HLEN)  frame_bytes[2] ^= 8'(1 << $urandom_range(0, 7));
        cookie = '{COOKIE_VALUE[31:24], COOKIE_VALUE[23:16], COOKIE_VALUE[15:8],
                   COOKIE_VALUE[7:0]};
        if (r.kind == FR_BAD_COOKIE)
            cookie[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        foreach (cookie[i])
            frame_bytes.push_back(cookie[i]);
        case (r.kind)
            FR_SHORT:
                while (frame_bytes.size() > r.len)
                    void'(frame_bytes.pop_back());
            FR_NO_TYPE:
            begin
                push_filler_options();
                frame_bytes.push_back(OPT_END);
            end
            FR_LEN0:
            begin
                // zero-length option, then the type
                frame_bytes.push_back(8'd12);
                frame_bytes.push_back(8'd0);
                frame_bytes.push_back(OPT_MSG_TYPE);
                frame_bytes.push_back(8'd1);
                frame_bytes.push_back(r.msg);
                frame_bytes.push_back(OPT_END);
            end
            FR_TYPE_LONG:
            begin
                // type option of length 2 is skipped, the length-1 one counts
                frame_bytes.push_back(OPT_MSG_TYPE);
                frame_bytes.push_back(8'd2);
                frame_bytes.push_back(8'($urandom));
                frame_bytes.push_back(8'($urandom));
                frame_bytes.push_back(OPT_MSG_TYPE);
                frame_bytes.push_back(8'd1);
                frame_bytes.push_back(r.msg);
                frame_bytes.push_back(OPT_END);
            end
            FR_END_FIRST:
            begin
                frame_bytes.push_back(OPT_END);
                frame_bytes.push_back(OPT_MSG_TYPE);
                frame_bytes.push_back(8'd1);
                frame_bytes.push_back(r.msg);
            end
            FR_CODE_LAST:
            begin
                push_filler_options();
                frame_bytes.push_back(OPT_MSG_TYPE);
            end
            FR_OVERRUN:
            begin
                // option data runs past the option area; the type after it is ignored
                pad_to(400);
                frame_bytes.push_back(8'd43);
                frame_bytes.push_back(8'd200);
                push_rand(200);
                frame_bytes.push_back(OPT_MSG_TYPE);
                frame_bytes.push_back(8'd1);
                frame_bytes.push_back(r.msg);
            end
            FR_LATE, FR_EDGE:
            begin
                // type option just outside, or ending on the last byte of, the area
                pad_to(r.kind == FR_LATE ? AREA_END : AREA_END - 3);
                frame_bytes.push_back(OPT_MSG_TYPE);
                frame_bytes.push_back(8'd1);
                frame_bytes.push_back(r.msg);
            end
            default:
            begin
                push_filler_options();
                frame_bytes.push_back(OPT_MSG_TYPE);
                frame_bytes.push_back(8'd1);
                frame_bytes.push_back(r.msg);
                if ($urandom_range(0, 1))
                    push_filler_options();
                frame_bytes.push_back(OPT_END);
                push_rand($urandom_range(0, 10));
                if (r.kind == FR_HUGE)
                    push_rand(2100 - frame_bytes.size());
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drives the built frame, one beat per handshake; returns predicted reply beats
    // the last beat stays on the bus so the next frame can follow without a gap
    task automatic send_frame(output int words);
        int gap;
        words = 0;
        foreach (frame_bytes[i])
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rx_valid <= 1'b1;
            rx_byte  <= frame_bytes[i];
            rx_last  <= (i == frame_bytes.size() - 1);
            do
                @(posedge clk);
            while (rx_stall);
            words += predict_beat(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // drops the request bus after the final frame of a run
    task automatic rx_idle();
        rx_valid <= 1'b0;
        rx_last  <= 1'b0;
    endtask

    // waits out every pending reply plus the reply path latency
    task automatic wait_drained();
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        write_regs(idx, val);
    endtask

    // all four registers, then a write to an index that does not exist
    task automatic load_regs(input logic [31:0] s, input logic [31:0] l,
                             input logic [31:0] t, input logic [31:0] m);
        cfg_write({6'd0, REG_SERVER}, s);
        cfg_write({6'd0, REG_LEASE}, l);
        cfg_write({6'd0, REG_SECS}, t);
        cfg_write({6'd0, REG_MASK}, m);
        cfg_write(8'($urandom_range(4, 255)), $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // short noise frames: never a reply, but they walk the frame state
    task automatic run_random_frames(input int count);
        frame_row_t r;
        int         w;
        for (int f = 0; f < count; f++)
        begin
            r.kind = FR_NOISE;
            r.msg = 8'($urandom);
            r.fill = FILL_RAND;
            r.len = $urandom_range(1, 12);
            r.words = -1;
            build_frame(r);
            send_frame(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Reply side: random stall runs, every accepted beat checked in order
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        reply_beat_t e;
        int r;
        if (!rst_n)
        begin
            tx_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (tx_valid && !tx_stall)
            begin
                if (pending_replies.size() == 0)
                    report($sformatf("reply beat %h with nothing expected", tx_word));
                else
                begin
                    e = pending_replies.pop_front();
                    if (tx_word !== e.word)
                        report($sformatf("tx_word %h, want %h", tx_word, e.word));
                    if (tx_valid_bytes !== e.nbytes)
                        report($sformatf("tx_valid_bytes %0d, want %0d",
                                         tx_valid_bytes, e.nbytes));
                    if (reply_is_ack !== e.ack)
                        report($sformatf("reply_is_ack %b, want %b", reply_is_ack, e.ack));
                    if (tx_last !== e.last)
                        report($sformatf("tx_last %b, want %b", tx_last, e.last));
                end
            end
            // pick a new run of ready or stalled cycles; mostly short, a few long
            if (stall_left == 0)
            begin
                r = $urandom_range(0, 9);
                if (no_idle || r < 5)
                begin
                    tx_stall <= 1'b0;
                    stall_left = $urandom_range(1, 20);
                end
                else
                begin
                    tx_stall <= 1'b1;
                    stall_left = (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                end
            end
            else
                stall_left--;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any accepted beat or register write
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((rx_valid && !rx_stall) || (tx_valid && !tx_stall) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("dhcp_offer_ack_responder_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed frames: checked at a glance where the outcome is obvious,
    // otherwise by the predictor alone
    // ------------------------------------------------------------------
    frame_row_t dir_rows [] = '{
        '{FR_SHORT,      MSG_DISCOVER, FILL_RAND, 1,   0},
        '{FR_SHORT,      MSG_REQUEST,  FILL_ONES, 12,  0},
        '{FR_NOISE,      MSG_DISCOVER, FILL_RAND, 5,   -1},
        '{FR_GOOD,       MSG_REQUEST,  FILL_RAND, 0,   REPLY_WORDS}
    };

    initial
    begin
        int w;
        regs = '{server: 32'hC0A8_0401, lease: 32'hC0A8_0402,
                 secs: 32'd3600, mask: 32'hFFFF_FF00};
        clear_frame_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        foreach (dir_rows[i])
        begin
            build_frame(dir_rows[i]);
            send_frame(w);
            if (dir_rows[i].words >= 0 && w != dir_rows[i].words)
                report($sformatf("directed frame %0d gives %0d reply beats, want %0d",
                                 i, w, dir_rows[i].words));
        end
        rx_idle();

        // random settings, then noise frames; one phase runs without idling
        wait_drained();
        load_regs($urandom, $urandom, $urandom, $urandom);
        no_idle = 1;
        run_random_frames(2);
        no_idle = 0;
        run_random_frames(2);
        rx_idle();
        wait_drained();

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("dhcp_offer_ack_responder_tb: PASS");
        else
            $display("dhcp_offer_ack_responder_tb: FAIL");
        $finish;
    end

endmodule
